[design/lttc_pkg.sv]
// Shared types and constants for the logo text to cell parser.
// Used by the front parser, the bundle queue, the result serialiser and the top level.
package lttc_pkg;

  // Text area limits
  localparam int MAX_ROWS    = 64;
  localparam int MAX_COLUMNS = 128;

  // Row counter also holds the extra row counted at end of text
  localparam int ROW_W = $clog2(MAX_ROWS + 2);
  localparam int COL_W = $clog2(MAX_COLUMNS + 1);

  // One input byte gives at most this many results
  localparam int SLOTS  = 4;
  localparam int SLOT_W = $clog2(SLOTS);

  // Queue between parser and serialiser
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic [20:0] BAD_POINT = 21'h00FFFD;

  // Input action codes
  localparam logic ACT_BYTE = 1'b0;
  localparam logic ACT_END  = 1'b1;

  // Result kind codes
  localparam logic KIND_CELL    = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  typedef struct packed {
    logic        kind;
    logic [5:0]  row;
    logic [6:0]  column;
    logic [20:0] code_point;
    logic [3:0]  color;
    logic [6:0]  total_rows;
    logic [7:0]  total_columns;
  } result_t;

  // All results caused by one input item, in order
  typedef struct packed {
    result_t [SLOTS-1:0] slot;
    logic [SLOT_W-1:0]   last_idx;
  } bundle_t;

  typedef struct packed {
    logic    valid;
    bundle_t bundle;
  } push_t;

endpackage

[design/lttc_front.sv]
// Front parser: accepts text bytes, runs the UTF-8 / escape / colour decode and
// places cells, then hands each item's results to the queue as one bundle. Uses lttc_pkg.
module lttc_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_action,
  input  logic [7:0]       in_text_byte,
  input  logic             q_full,
  output logic             in_stall,
  output lttc_pkg::push_t  push_o
);
  import lttc_pkg::*;

  localparam logic [7:0] CH_LF      = 8'h0A;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_ESC     = 8'h1B;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_DOLLAR  = 8'h24;
  localparam logic [7:0] CH_ONE     = 8'h31;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_BRACKET = 8'h5B;
  localparam logic [7:0] CH_UP_A    = 8'h41;
  localparam logic [7:0] CH_UP_Z    = 8'h5A;
  localparam logic [7:0] CH_LO_A    = 8'h61;
  localparam logic [7:0] CH_LO_Z    = 8'h7A;

  typedef enum logic [2:0] {
    MODE_NORMAL,
    MODE_UTF8,
    MODE_DOLLAR,
    MODE_ESC,
    MODE_CSI
  } mode_t;

  mode_t            mode_r, mode_nxt;
  logic [1:0]       seq_rem_r, seq_rem_nxt;
  logic [1:0]       seq_seen_r, seq_seen_nxt;
  logic [20:0]      partial_r, partial_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic [COL_W-1:0] col_r, col_nxt;
  logic [COL_W-1:0] widest_r, widest_nxt;
  logic [3:0]       color_r, color_nxt;

  logic             accept;
  logic [7:0]       b;
  logic             is_cont, is_digit, is_letter;
  logic             do_normal, newline, summary, dollar_cell, tail_en;
  logic [20:0]      tail_cp;
  logic [20:0]      part;
  logic [1:0]       fc;
  logic [SLOTS-1:0] en;
  logic [20:0]      cp [SLOTS];
  logic [COL_W-1:0] col_w;
  logic [SLOT_W:0]  k;
  logic [ROW_W-1:0] end_rows;
  logic [COL_W-1:0] end_widest;
  result_t          cell_w;
  result_t          sum_w;
  bundle_t          bundle_w;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign b        = in_text_byte;
  assign is_cont  = (b[7:6] == 2'b10);
  assign is_digit = (b >= CH_ONE) && (b <= CH_NINE);
  assign is_letter = ((b >= CH_UP_A) && (b <= CH_UP_Z)) ||
                     ((b >= CH_LO_A) && (b <= CH_LO_Z));
  assign part     = {partial_r[14:0], b[5:0]};

  // Decode: work out state updates and which characters get placed
  always_comb begin
    mode_nxt     = mode_r;
    seq_rem_nxt  = seq_rem_r;
    seq_seen_nxt = seq_seen_r;
    partial_nxt  = partial_r;
    color_nxt    = color_r;
    fc           = 2'd0;
    dollar_cell  = 1'b0;
    tail_en      = 1'b0;
    tail_cp      = BAD_POINT;
    do_normal    = 1'b0;
    newline      = 1'b0;
    summary      = 1'b0;

    if (accept) begin
      if (in_action == ACT_END) begin
        if (mode_r == MODE_UTF8) begin
          fc = seq_seen_r;
        end else if (mode_r == MODE_DOLLAR) begin
          dollar_cell = 1'b1;
        end
        summary = 1'b1;
      end else if (row_r < ROW_W'(MAX_ROWS)) begin
        unique case (mode_r)
          MODE_UTF8: begin
            if (is_cont) begin
              if (seq_rem_r <= 2'd1) begin
                tail_en      = 1'b1;
                tail_cp      = part;
                seq_seen_nxt = 2'd0;
                seq_rem_nxt  = 2'd0;
                partial_nxt  = 21'd0;
                mode_nxt     = MODE_NORMAL;
              end else begin
                partial_nxt  = part;
                seq_seen_nxt = seq_seen_r + 2'd1;
                seq_rem_nxt  = seq_rem_r - 2'd1;
              end
            end else begin
              // broken sequence: one bad cell per stored byte, then redo the byte
              fc           = seq_seen_r;
              seq_seen_nxt = 2'd0;
              seq_rem_nxt  = 2'd0;
              partial_nxt  = 21'd0;
              mode_nxt     = MODE_NORMAL;
              do_normal    = 1'b1;
            end
          end
          MODE_DOLLAR: begin
            mode_nxt = MODE_NORMAL;
            if (is_digit) begin
              color_nxt = 4'(b - CH_ONE);
            end else if (b == CH_DOLLAR) begin
              dollar_cell = 1'b1;
            end else begin
              dollar_cell = 1'b1;
              do_normal   = 1'b1;
            end
          end
          MODE_ESC: begin
            if (b == CH_BRACKET) begin
              mode_nxt = MODE_CSI;
            end else begin
              mode_nxt  = MODE_NORMAL;
              do_normal = 1'b1;
            end
          end
          MODE_CSI: begin
            if (is_letter) begin
              mode_nxt = MODE_NORMAL;
            end
          end
          default: begin
            mode_nxt  = MODE_NORMAL;
            do_normal = 1'b1;
          end
        endcase

        // Plain byte handling
        if (do_normal) begin
          if (b == CH_LF) begin
            newline = 1'b1;
          end else if (b == CH_CR) begin
            tail_en = 1'b0;
          end else if (b == CH_ESC) begin
            mode_nxt = MODE_ESC;
          end else if (b == CH_DOLLAR) begin
            mode_nxt = MODE_DOLLAR;
          end else if (!b[7]) begin
            tail_en = 1'b1;
            tail_cp = {13'd0, b};
          end else if (b[7:5] == 3'b110) begin
            partial_nxt  = {16'd0, b[4:0]};
            seq_rem_nxt  = 2'd1;
            seq_seen_nxt = 2'd1;
            mode_nxt     = MODE_UTF8;
          end else if (b[7:4] == 4'b1110) begin
            partial_nxt  = {17'd0, b[3:0]};
            seq_rem_nxt  = 2'd2;
            seq_seen_nxt = 2'd1;
            mode_nxt     = MODE_UTF8;
          end else if (b[7:3] == 5'b11110) begin
            partial_nxt  = {18'd0, b[2:0]};
            seq_rem_nxt  = 2'd3;
            seq_seen_nxt = 2'd1;
            mode_nxt     = MODE_UTF8;
          end else begin
            tail_en = 1'b1;
            tail_cp = BAD_POINT;
          end
        end
      end
    end
  end

  // Placement: walk the candidate characters in order, advancing the column
  always_comb begin
    en[0] = (fc != 2'd0) || dollar_cell;
    en[1] = (fc >= 2'd2);
    en[2] = (fc == 2'd3);
    en[3] = tail_en;
    cp[0] = dollar_cell ? {13'd0, CH_DOLLAR} : BAD_POINT;
    cp[1] = BAD_POINT;
    cp[2] = BAD_POINT;
    cp[3] = tail_cp;

    col_w    = col_r;
    k        = '0;
    bundle_w = '0;
    cell_w   = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if (en[i] && (col_w < COL_W'(MAX_COLUMNS))) begin
        if (cp[i] != {13'd0, CH_SPACE}) begin
          cell_w.kind       = KIND_CELL;
          cell_w.row        = 6'(row_r);
          cell_w.column     = 7'(col_w);
          cell_w.code_point = cp[i];
          cell_w.color      = color_r;
          bundle_w.slot[k[SLOT_W-1:0]] = cell_w;
          k = k + 1'b1;
        end
        col_w = col_w + 1'b1;
      end
    end

    // End of text totals
    end_rows   = row_r + ROW_W'(col_w != '0);
    end_widest = (col_w > widest_r) ? col_w : widest_r;
    sum_w               = '0;
    sum_w.kind          = KIND_SUMMARY;
    sum_w.total_rows    = 7'(end_rows);
    sum_w.total_columns = 8'(end_widest);
    if (summary) begin
      bundle_w.slot[k[SLOT_W-1:0]] = sum_w;
      k = k + 1'b1;
    end
    bundle_w.last_idx = SLOT_W'(k - 1'b1);

    push_o.valid  = accept && (k != '0);
    push_o.bundle = bundle_w;
  end

  // Row, column and widest line updates
  always_comb begin
    row_nxt    = row_r;
    col_nxt    = col_w;
    widest_nxt = widest_r;
    if (newline) begin
      widest_nxt = (col_w > widest_r) ? col_w : widest_r;
      row_nxt    = row_r + 1'b1;
      col_nxt    = '0;
    end
  end

  // Parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= MODE_NORMAL;
      seq_rem_r  <= 2'd0;
      seq_seen_r <= 2'd0;
      partial_r  <= 21'd0;
      row_r      <= '0;
      col_r      <= '0;
      widest_r   <= '0;
      color_r    <= 4'd0;
    end else if (summary) begin
      // a new text starts from the reset state
      mode_r     <= MODE_NORMAL;
      seq_rem_r  <= 2'd0;
      seq_seen_r <= 2'd0;
      partial_r  <= 21'd0;
      row_r      <= '0;
      col_r      <= '0;
      widest_r   <= '0;
      color_r    <= 4'd0;
    end else if (accept) begin
      mode_r     <= mode_nxt;
      seq_rem_r  <= seq_rem_nxt;
      seq_seen_r <= seq_seen_nxt;
      partial_r  <= partial_nxt;
      row_r      <= row_nxt;
      col_r      <= col_nxt;
      widest_r   <= widest_nxt;
      color_r    <= newline ? 4'd0 : color_nxt;
    end
  end

  // End of text always leaves the parser back at the start of a fresh text
  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (in_action == ACT_END) |=> (row_r == '0) && (col_r == '0) &&
                                         (mode_r == MODE_NORMAL))
    else $error("parser state not cleared after end of text");

endmodule

[design/lttc_queue.sv]
// Short queue of result bundles between the front parser and the serialiser.
// Register based, one write and one head read per cycle. Uses lttc_pkg.
module lttc_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  lttc_pkg::push_t   push_i,
  input  logic              pop_i,
  output logic              full_o,
  output logic              head_valid_o,
  output lttc_pkg::bundle_t head_o
);
  import lttc_pkg::*;

  bundle_t            mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]    count_r, count_nxt;

  assign full_o       = (count_r == (QPTR_W + 1)'(QUEUE_DEPTH));
  assign head_valid_o = (count_r != '0);
  assign head_o       = mem_r[rd_ptr_r];

  // Pointer and occupancy update
  always_comb begin
    wr_ptr_nxt = push_i.valid ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop_i ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + (QPTR_W + 1)'(push_i.valid) - (QPTR_W + 1)'(pop_i);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Bundle storage
  always_ff @(posedge clk) begin
    if (push_i.valid) begin
      mem_r[wr_ptr_r] <= push_i.bundle;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push_i.valid |-> !full_o || pop_i)
    else $error("bundle written into a full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop_i |-> head_valid_o)
    else $error("bundle popped from an empty queue");

endmodule

[design/lttc_back.sv]
// Result serialiser: walks the head bundle of the queue, one result per transfer,
// and flags the last result of each input item. Uses lttc_pkg.
module lttc_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              head_valid_i,
  input  lttc_pkg::bundle_t head_i,
  output logic              pop_o,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_kind,
  output logic [5:0]        out_cell_row,
  output logic [6:0]        out_cell_column,
  output logic [20:0]       out_code_point,
  output logic [3:0]        out_color_index,
  output logic [6:0]        out_total_rows,
  output logic [7:0]        out_total_columns,
  output logic              out_run_last
);
  import lttc_pkg::*;

  logic [SLOT_W-1:0] idx_r, idx_nxt;
  result_t           cur;
  logic              xfer;

  assign cur               = head_i.slot[idx_r];
  assign out_valid         = head_valid_i;
  assign out_kind          = cur.kind;
  assign out_cell_row      = cur.row;
  assign out_cell_column   = cur.column;
  assign out_code_point    = cur.code_point;
  assign out_color_index   = cur.color;
  assign out_total_rows    = cur.total_rows;
  assign out_total_columns = cur.total_columns;
  assign out_run_last      = (idx_r == head_i.last_idx);

  assign xfer  = out_valid && !out_stall;
  assign pop_o = xfer && out_run_last;

  // Slot index within the head bundle
  always_comb begin
    idx_nxt = idx_r;
    if (xfer) begin
      idx_nxt = out_run_last ? '0 : idx_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
    end else begin
      idx_r <= idx_nxt;
    end
  end

  a_idx_in_bundle: assert property (@(posedge clk) disable iff (!rst_n)
    head_valid_i |-> idx_r <= head_i.last_idx)
    else $error("slot index beyond the head bundle");

  a_summary_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == KIND_SUMMARY) |-> out_run_last)
    else $error("end summary not the last result of its item");

endmodule

[design/logo_text_to_cell_parser_top.sv]
// Top level of the logo text to cell parser.
// Instantiates lttc_front, lttc_queue and lttc_back; uses lttc_pkg.
//
// Takes one logo text byte (or an end-of-text marker) per transfer and gives a
// character cell for each visible character, plus a summary with the row count
// and widest line at end of text. A new item can be accepted every cycle while
// the queue is not full; its results leave the queue one per output transfer,
// so an item that causes several results (a broken UTF-8 sequence, or a cut-off
// one at end of text, gives up to four) holds the output for one transfer per
// result. Up to four items' worth of results wait in the queue between parser
// and serialiser; in_stall rises only when that queue is full. Items that give
// no result (spaces, colour markers, escapes) pass without using the output.
module logo_text_to_cell_parser_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_action,
  input  logic [7:0]  in_text_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_kind,
  output logic [5:0]  out_cell_row,
  output logic [6:0]  out_cell_column,
  output logic [20:0] out_code_point,
  output logic [3:0]  out_color_index,
  output logic [6:0]  out_total_rows,
  output logic [7:0]  out_total_columns,
  output logic        out_run_last
);
  import lttc_pkg::*;

  push_t   push;
  logic    q_full;
  logic    head_valid;
  bundle_t head;
  logic    pop;

  // Parser front end
  lttc_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_action    (in_action),
    .in_text_byte (in_text_byte),
    .q_full       (q_full),
    .in_stall     (in_stall),
    .push_o       (push)
  );

  // Bundle queue
  lttc_queue u_queue (
    .clk          (clk),
    .rst_n        (rst_n),
    .push_i       (push),
    .pop_i        (pop),
    .full_o       (q_full),
    .head_valid_o (head_valid),
    .head_o       (head)
  );

  // Result serialiser
  lttc_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .head_valid_i      (head_valid),
    .head_i            (head),
    .pop_o             (pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_kind          (out_kind),
    .out_cell_row      (out_cell_row),
    .out_cell_column   (out_cell_column),
    .out_code_point    (out_code_point),
    .out_color_index   (out_color_index),
    .out_total_rows    (out_total_rows),
    .out_total_columns (out_total_columns),
    .out_run_last      (out_run_last)
  );

endmodule

[tb/sv/tb.sv]
// Testbench for logo_text_to_cell_parser_top: directed and random logo text with a
// built-in predictor of the cells and end-of-text summaries. Depends on lttc_pkg.
// Both channels use valid/stall with random idle cycles on each side.
module tb;
  import lttc_pkg::*;

  // Text bytes with a meaning of their own
  localparam logic [7:0] CH_LF      = 8'h0A;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_ESC     = 8'h1B;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_DOLLAR  = "$";
  localparam logic [7:0] CH_BRACKET = "[";
  localparam logic [7:0] CH_ONE     = "1";
  localparam logic [7:0] CH_NINE    = "9";
  localparam logic [7:0] CH_UP_A    = "A";
  localparam logic [7:0] CH_UP_Z    = "Z";
  localparam logic [7:0] CH_LO_A    = "a";
  localparam logic [7:0] CH_LO_Z    = "z";

  localparam int TAIL_CYCLES = 12;
  localparam int CYCLE_LIMIT = 400000;
  localparam int MAX_REPORTS = 10;

  typedef enum logic [2:0] {PM_NORMAL, PM_UTF8, PM_DOLLAR, PM_ESC, PM_CSI} text_mode_t;

  typedef struct packed {
    logic        kind;
    logic [5:0]  row;
    logic [6:0]  column;
    logic [20:0] code_point;
    logic [3:0]  colour;
    logic [6:0]  total_rows;
    logic [7:0]  total_columns;
    logic        last;
  } cell_rec_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_action = ACT_BYTE;
  logic [7:0]  in_text_byte = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_kind;
  logic [5:0]  out_cell_row;
  logic [6:0]  out_cell_column;
  logic [20:0] out_code_point;
  logic [3:0]  out_color_index;
  logic [6:0]  out_total_rows;
  logic [7:0]  out_total_columns;
  logic        out_run_last;

  // Idle control: a calm side never waits
  bit send_calm = 1'b0;
  bit take_calm = 1'b0;
  int live_items = 0;
  int fault_count = 0;
  int cycle_count = 0;

  cell_rec_t cells_due[$];

  // Predictor state
  text_mode_t  mode_now;
  int          seq_left;
  int          seq_count;
  logic [20:0] acc_point;
  int          line_no;
  int          col_no;
  int          widest;
  int          colour;
  cell_rec_t   step_res[4];
  int          step_n;

  always #10 clk = ~clk;

  logo_text_to_cell_parser_top u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_action        (in_action),
    .in_text_byte     (in_text_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_kind         (out_kind),
    .out_cell_row     (out_cell_row),
    .out_cell_column  (out_cell_column),
    .out_code_point   (out_code_point),
    .out_color_index  (out_color_index),
    .out_total_rows   (out_total_rows),
    .out_total_columns(out_total_columns),
    .out_run_last     (out_run_last)
  );

  // ---------------------------------------------------------------- predictor

  function automatic void clear_text_state();
    mode_now  = PM_NORMAL;
    seq_left  = 0;
    seq_count = 0;
    acc_point = '0;
    line_no   = 0;
    col_no    = 0;
    widest    = 0;
    colour    = 0;
  endfunction

  // At most four results per transfer; extras are dropped
  function automatic void add_result(logic kind, int row, int col, logic [20:0] cp,
                                     int clr, int trows, int tcols);
    if (step_n < 4) begin
      step_res[step_n].kind          = kind;
      step_res[step_n].row           = 6'(row);
      step_res[step_n].column        = 7'(col);
      step_res[step_n].code_point    = cp;
      step_res[step_n].colour        = 4'(clr);
      step_res[step_n].total_rows    = 7'(trows);
      step_res[step_n].total_columns = 8'(tcols);
      step_res[step_n].last          = 1'b0;
      step_n++;
    end
  endfunction

  // Columns stop at the limit; spaces take a column but give no cell
  function automatic void place_glyph(logic [20:0] cp);
    if (col_no < MAX_COLUMNS) begin
      if (cp != 21'(CH_SPACE))
        add_result(KIND_CELL, line_no, col_no, cp, colour, 0, 0);
      col_no++;
    end
  endfunction

  // One replacement cell for the lead and each stored continuation
  function automatic void flush_broken_seq();
    for (int i = 0; i < seq_count; i++)
      place_glyph(BAD_POINT);
    seq_count = 0;
    seq_left  = 0;
    acc_point = '0;
    mode_now  = PM_NORMAL;
  endfunction

  function automatic void start_seq(logic [20:0] bits, int more);
    acc_point = bits;
    seq_left  = more;
    seq_count = 1;
    mode_now  = PM_UTF8;
  endfunction

  function automatic void plain_byte(logic [7:0] b);
    if (b == CH_LF) begin
      if (col_no > widest)
        widest = col_no;
      line_no++;
      col_no = 0;
      colour = 0;
    end else if (b == CH_CR) begin
      // dropped
    end else if (b == CH_ESC) begin
      mode_now = PM_ESC;
    end else if (b == CH_DOLLAR) begin
      mode_now = PM_DOLLAR;
    end else if (b < 8'h80) begin
      place_glyph(21'(b));
    end else if ((b & 8'hE0) == 8'hC0) begin
      start_seq(21'(b & 8'h1F), 1);
    end else if ((b & 8'hF0) == 8'hE0) begin
      start_seq(21'(b & 8'h0F), 2);
    end else if ((b & 8'hF8) == 8'hF0) begin
      start_seq(21'(b & 8'h07), 3);
    end else begin
      place_glyph(BAD_POINT);
    end
  endfunction

  function automatic void take_text_byte(logic [7:0] b);
    if (line_no >= MAX_ROWS)
      return;
    case (mode_now)
      PM_UTF8: begin
        if (b[7:6] == 2'b10) begin
          acc_point = {acc_point[14:0], b[5:0]};
          seq_count++;
          if (seq_left > 0)
            seq_left--;
          if (seq_left == 0) begin
            place_glyph(acc_point);
            seq_count = 0;
            acc_point = '0;
            mode_now  = PM_NORMAL;
          end
        end else begin
          flush_broken_seq();
          plain_byte(b);
        end
      end
      PM_DOLLAR: begin
        mode_now = PM_NORMAL;
        if (b >= CH_ONE && b <= CH_NINE) begin
          colour = b - CH_ONE;
        end else if (b == CH_DOLLAR) begin
          place_glyph(21'(CH_DOLLAR));
        end else begin
          place_glyph(21'(CH_DOLLAR));
          plain_byte(b);
        end
      end
      PM_ESC: begin
        mode_now = PM_NORMAL;
        if (b == CH_BRACKET)
          mode_now = PM_CSI;
        else
          plain_byte(b);
      end
      PM_CSI: begin
        if ((b >= CH_UP_A && b <= CH_UP_Z) || (b >= CH_LO_A && b <= CH_LO_Z))
          mode_now = PM_NORMAL;
      end
      default: begin
        mode_now = PM_NORMAL;
        plain_byte(b);
      end
    endcase
  endfunction

  // Works out every result of one accepted transfer and queues it
  function automatic void predict_cells(logic act, logic [7:0] b);
    cell_rec_t r;
    step_n = 0;
    if (act == ACT_BYTE) begin
      take_text_byte(b);
    end else begin
      if (mode_now == PM_UTF8)
        flush_broken_seq();
      else if (mode_now == PM_DOLLAR)
        place_glyph(21'(CH_DOLLAR));
      mode_now = PM_NORMAL;
      if (col_no > 0) begin
        if (col_no > widest)
          widest = col_no;
        line_no++;
      end
      add_result(KIND_SUMMARY, 0, 0, '0, 0, line_no, widest);
      clear_text_state();
    end
    for (int i = 0; i < step_n; i++) begin
      r = step_res[i];
      r.last = (i == step_n - 1);
      cells_due.push_back(r);
    end
  endfunction

  // ---------------------------------------------------------------- driving

  function automatic int pick_wait(bit calm);
    return calm ? 0 : $urandom_range(0, 6);
  endfunction

  // Called at a rising edge; returns at the edge where the transfer happens
  task automatic send_item(logic act, logic [7:0] b);
    int gap;
    gap = pick_wait(send_calm);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_action    <= act;
    in_text_byte <= b;
    do @(posedge clk); while (in_stall);
    if (act == ACT_END || line_no < MAX_ROWS)
      live_items++;
    predict_cells(act, b);
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++)
      send_item(ACT_BYTE, s[i]);
  endtask

  task automatic send_end();
    send_item(ACT_END, 8'($urandom_range(0, 255)));
  endtask

  // Sender holds off until every expected result has been taken
  task automatic wait_for_drain();
    in_valid <= 1'b0;
    while (cells_due.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic send_utf8_seq(bit broken);
    int len;
    logic [7:0] b;
    len = $urandom_range(2, 4);
    case (len)
      2:       send_item(ACT_BYTE, 8'hC0 | 8'($urandom_range(0, 31)));
      3:       send_item(ACT_BYTE, 8'hE0 | 8'($urandom_range(0, 15)));
      default: send_item(ACT_BYTE, 8'hF0 | 8'($urandom_range(0, 7)));
    endcase
    repeat (broken ? $urandom_range(0, len - 2) : len - 1)
      send_item(ACT_BYTE, 8'h80 | 8'($urandom_range(0, 63)));
    if (broken) begin
      b = 8'($urandom_range(0, 255));
      if (b[7:6] == 2'b10)
        b[6] = 1'b1;
      send_item(ACT_BYTE, b);
    end
  endtask

  // Mostly well-formed text with random content, some raw noise
  task automatic send_random_token();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 28) begin
      send_item(ACT_BYTE, 8'($urandom_range(8'h21, 8'h7E)));
    end else if (pick < 34) begin
      send_item(ACT_BYTE, CH_SPACE);
    end else if (pick < 39) begin
      send_item(ACT_BYTE, CH_LF);
    end else if (pick < 41) begin
      send_item(ACT_BYTE, CH_CR);
    end else if (pick < 46) begin
      send_item(ACT_BYTE, CH_DOLLAR);
      send_item(ACT_BYTE, CH_ONE + 8'($urandom_range(0, 8)));
    end else if (pick < 48) begin
      send_item(ACT_BYTE, CH_DOLLAR);
      send_item(ACT_BYTE, CH_DOLLAR);
    end else if (pick < 50) begin
      send_item(ACT_BYTE, CH_DOLLAR);
      send_item(ACT_BYTE, 8'($urandom_range(0, 255)));
    end else if (pick < 64) begin
      send_utf8_seq(1'b0);
    end else if (pick < 70) begin
      send_utf8_seq(1'b1);
    end else if (pick < 75) begin
      send_item(ACT_BYTE, CH_ESC);
      send_item(ACT_BYTE, CH_BRACKET);
      repeat ($urandom_range(0, 3))
        send_item(ACT_BYTE, 8'($urandom_range(8'h30, 8'h3B)));
      if ($urandom_range(0, 1))
        send_item(ACT_BYTE, 8'($urandom_range(CH_UP_A, CH_UP_Z)));
      else
        send_item(ACT_BYTE, 8'($urandom_range(CH_LO_A, CH_LO_Z)));
    end else if (pick < 77) begin
      send_item(ACT_BYTE, CH_ESC);
      send_item(ACT_BYTE, 8'($urandom_range(0, 255)));
    end else if (pick < 79) begin
      send_end();
    end else begin
      send_item(ACT_BYTE, 8'($urandom_range(0, 255)));
    end
  endtask

  // ---------------------------------------------------------------- tests

  // Printable text, spaces, colour markers, control bytes and escapes
  task automatic test_plain_and_markers();
    send_text("A z");
    send_item(ACT_BYTE, CH_CR);
    send_text("$3Q$$$x");
    send_item(ACT_BYTE, 8'h00);
    send_item(ACT_BYTE, 8'h7F);
    send_item(ACT_BYTE, CH_ESC);
    send_text("[2J");
    send_item(ACT_BYTE, CH_ESC);
    send_text("Q");
    send_item(ACT_BYTE, CH_LF);
    send_text("B");
    send_end();
  endtask

  // Good sequences of every length, stray bytes, broken and cut-off sequences
  task automatic test_utf8_forms();
    send_item(ACT_BYTE, 8'hC3);
    send_item(ACT_BYTE, 8'hA9);
    send_item(ACT_BYTE, 8'hE2);
    send_item(ACT_BYTE, 8'h82);
    send_item(ACT_BYTE, 8'hAC);
    send_item(ACT_BYTE, 8'hF0);
    send_item(ACT_BYTE, 8'h9F);
    send_item(ACT_BYTE, 8'h98);
    send_item(ACT_BYTE, 8'h80);
    send_item(ACT_BYTE, 8'hFF);
    send_item(ACT_BYTE, 8'h80);
    send_item(ACT_BYTE, 8'hF7);
    send_item(ACT_BYTE, 8'hBF);
    send_item(ACT_BYTE, 8'hBF);
    send_text("A");
    send_item(ACT_BYTE, 8'hE2);
    send_item(ACT_BYTE, 8'h82);
    send_end();
  endtask

  // Things left pending when the text ends
  task automatic test_end_pending();
    send_text("$");
    send_end();
    send_item(ACT_BYTE, CH_ESC);
    send_end();
    send_item(ACT_BYTE, CH_ESC);
    send_text("[1");
    send_end();
    send_end();
    send_text("x");
    send_end();
  endtask

  // Line runs past the column limit, multibyte and dollar cells at the edge
  task automatic test_column_limit();
    for (int i = 0; i < MAX_COLUMNS - 2; i++)
      send_item(ACT_BYTE, CH_LO_A + 8'(i % 26));
    send_text("$$");
    send_item(ACT_BYTE, 8'hC3);
    send_item(ACT_BYTE, 8'hA9);
    send_text("Q");
    send_item(ACT_BYTE, 8'hE2);
    send_item(ACT_BYTE, 8'h82);
    send_item(ACT_BYTE, 8'hAC);
    send_text("$2R");
    send_item(ACT_BYTE, CH_LF);
    send_text("k");
    send_end();
  endtask

  // Rows fill up, later bytes are ignored until end of text
  task automatic test_row_limit();
    send_calm = 1'b1;
    take_calm = 1'b1;
    for (int i = 0; i < MAX_ROWS + 2; i++) begin
      send_item(ACT_BYTE, CH_UP_A + 8'(i % 26));
      send_item(ACT_BYTE, CH_LF);
    end
    send_text("tail$");
    send_end();
    send_calm = 1'b0;
    take_calm = 1'b0;
  endtask

  // Random text in phases with and without idling on each side
  task automatic test_random_text();
    int target;
    for (int phase = 0; phase < 4; phase++) begin
      send_calm = (phase == 1);
      take_calm = (phase == 2);
      target = live_items + 12;
      while (live_items < target)
        send_random_token();
      if (phase == 1)
        wait_for_drain();
    end
    send_calm = 1'b0;
    take_calm = 1'b0;
    send_end();
  endtask

  // ---------------------------------------------------------------- checking

  function automatic string describe_result(cell_rec_t r);
    return $sformatf("kind=%0d row=%0d col=%0d cp=%h colour=%0d rows=%0d cols=%0d last=%0d",
                     r.kind, r.row, r.column, r.code_point, r.colour,
                     r.total_rows, r.total_columns, r.last);
  endfunction

  task automatic report_fault(string what);
    fault_count++;
    if (fault_count <= MAX_REPORTS)
      $display("MISMATCH: %s", what);
  endtask

  // Receiver: random stalls, compares each transfer with the oldest expectation
  initial begin : result_check
    int hold;
    cell_rec_t got;
    cell_rec_t want;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      hold = pick_wait(take_calm);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      got = '{out_kind, out_cell_row, out_cell_column, out_code_point, out_color_index,
              out_total_rows, out_total_columns, out_run_last};
      if (cells_due.size() == 0) begin
        report_fault({"unexpected result ", describe_result(got)});
      end else begin
        want = cells_due.pop_front();
        if (got !== want)
          report_fault({"expected ", describe_result(want), " got ", describe_result(got)});
      end
    end
  end

  // Run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    clear_text_state();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    test_plain_and_markers();
    test_utf8_forms();
    test_end_pending();
    test_column_limit();
    test_row_limit();
    test_random_text();
    wait_for_drain();
    if (fault_count == 0 && cells_due.size() == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule

[files.f]
design/lttc_pkg.sv
design/lttc_front.sv
design/lttc_queue.sv
design/lttc_back.sv
design/logo_text_to_cell_parser_top.sv
tb/sv/tb.sv
